@@ rtl/stpr_pkg.sv @@
// shared constants, types and cosine table for the swept resonator
package stpr_pkg;

   localparam int COS_TABLE_DEPTH = 1024;
   localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH);
   localparam int HISTORY_WIDTH = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 25;

   typedef enum logic [1:0] {
      FUNC_FILTER = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_SET    = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQ  = 2'd0,
      CSR_RESON = 2'd1,
      CSR_GAIN  = 2'd2,
      CSR_RATE  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [14:0] freq;
      logic [15:0] reson;
      logic [15:0] gain;
      logic [24:0] rate;
   } cfg_type;

   // commands from controller to datapath
   typedef struct packed {
      logic start;     // latch targets, compute deltas
      logic set;       // jump to targets
      logic clear;     // clear history
      logic advance;   // advance sweep phase
      logic interp;    // interpolate current values
      logic coefs;     // recompute coefficients
      logic filt;      // run the filter mac and output
   } cmd_type;

   typedef struct packed {
      logic sweeping;
   } status_type;

   // cosine table entry, Q1.16, Taylor series through x^14
   function automatic logic [16:0] cos_entry(input int k);
      logic [63:0] x, x2, term;
      longint acc;
      x = (64'(k) * 64'd1686629713) / COS_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      acc = (acc > 0) ? ((acc + 8192) >>> 14) : 0;
      if (acc > 65536) acc = 65536;
      return 17'(acc);
   endfunction

endpackage

@@ rtl/stpr_if.sv @@
// valid/ready channel interfaces for requests and responses
interface stpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic signed [15:0] sample_in;
   modport source (output valid, func, sample_in, input ready);
   modport sink (input valid, func, sample_in, output ready);
endinterface

interface stpr_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [23:0] sample_out;
   logic        sweep_active;
   modport source (output valid, sample_out, sweep_active, input ready);
   modport sink (input valid, sample_out, sweep_active, output ready);
endinterface

@@ rtl/stpr_datapath.sv @@
// sweep state, cosine lookup, coefficient and filter arithmetic
module stpr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  stpr_pkg::cfg_type    cfg,
   input  stpr_pkg::cmd_type    cmd,
   input  logic signed [15:0]   sample,
   output stpr_pkg::status_type status,
   output logic signed [23:0]   y_out
);
   import stpr_pkg::*;

   localparam int HW = HISTORY_WIDTH;

   logic [14:0] base_f_ff, cur_f_ff, lat_f_ff;
   logic [15:0] base_r_ff, cur_r_ff, lat_r_ff;
   logic [15:0] base_g_ff, cur_g_ff, lat_g_ff;
   logic signed [15:0] dlt_f_ff;
   logic signed [16:0] dlt_r_ff, dlt_g_ff;
   logic [24:0] phase_ff;
   logic        sweep_ff;
   logic signed [17:0] a1_ff, a2_ff;
   logic signed [HW-1:0] y1_ff, y2_ff;
   logic signed [23:0] yo_ff;

   // quarter-wave cosine rom, filled from the package function at elaboration
   logic [16:0] cos_rom [COS_TABLE_DEPTH];
   logic [16:0] lval_ff;

   initial begin
      for (int k = 0; k < COS_TABLE_DEPTH; k++) cos_rom[k] = cos_entry(k);
   end

   // cosine of current freq
   logic [13:0] off;
   logic [14:0] offm;
   logic [14:0] oq;
   logic [COS_IDX_W:0] idx;
   logic signed [17:0] cosv;

   always_comb begin
      off = cur_f_ff[13:0];
      offm = 15'd16384 - {1'b0, off};
      oq = cur_f_ff[14] ? offm : {1'b0, off};
      idx = (COS_IDX_W+1)'((32'(oq) * COS_TABLE_DEPTH) >> 14);
      cosv = cur_f_ff[14] ? -$signed({1'b0, lval_ff}) : $signed({1'b0, lval_ff});
   end

   // registered rom read, the index past the table reads as zero
   always_ff @(posedge clock) begin
      if (idx >= (COS_IDX_W+1)'(COS_TABLE_DEPTH)) lval_ff <= '0;
      else lval_ff <= cos_rom[idx[COS_IDX_W-1:0]];
   end

   logic [25:0] ph_sum;
   logic signed [42:0] pf, pr, pg;
   logic signed [34:0] prc;
   logic [31:0] rr;
   logic signed [HW+19:0] acc;
   logic signed [HW+19:0] ysh;
   logic signed [HW-1:0] ysat;

   always_comb begin
      ph_sum = {1'b0, phase_ff} + {1'b0, cfg.rate};
      pf = 43'(dlt_f_ff) * $signed({18'd0, phase_ff});
      pr = 43'(dlt_r_ff) * $signed({18'd0, phase_ff});
      pg = 43'(dlt_g_ff) * $signed({18'd0, phase_ff});
      prc = $signed({19'd0, cur_r_ff}) * 35'(cosv);
      rr = cur_r_ff * cur_r_ff;
      acc = (HW+20)'($signed({2'b0, cur_g_ff}) * sample) * 2
          + (HW+20)'(a1_ff) * (HW+20)'(y1_ff)
          + (HW+20)'(a2_ff) * (HW+20)'(y2_ff) + 32768;
      ysh = acc >>> 16;
      if (ysh > (HW+20)'((64'sd1 <<< (HW-1)) - 1)) ysat = {1'b0, {(HW-1){1'b1}}};
      else if (ysh < -(HW+20)'(64'sd1 <<< (HW-1))) ysat = {1'b1, {(HW-1){1'b0}}};
      else ysat = HW'(ysh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_f_ff <= '0; cur_f_ff <= '0; lat_f_ff <= '0;
         base_r_ff <= '0; cur_r_ff <= '0; lat_r_ff <= '0;
         base_g_ff <= 16'd32768; cur_g_ff <= 16'd32768; lat_g_ff <= 16'd32768;
         dlt_f_ff <= '0; dlt_r_ff <= '0; dlt_g_ff <= '0;
         phase_ff <= '0; sweep_ff <= 1'b0;
         a1_ff <= '0; a2_ff <= '0; y1_ff <= '0; y2_ff <= '0;
         yo_ff <= '0;
      end else begin
         if (cmd.start) begin
            lat_f_ff <= cfg.freq; lat_r_ff <= cfg.reson; lat_g_ff <= cfg.gain;
            base_f_ff <= cur_f_ff; base_r_ff <= cur_r_ff; base_g_ff <= cur_g_ff;
            dlt_f_ff <= $signed({1'b0, cfg.freq}) - $signed({1'b0, cur_f_ff});
            dlt_r_ff <= $signed({1'b0, cfg.reson}) - $signed({1'b0, cur_r_ff});
            dlt_g_ff <= $signed({1'b0, cfg.gain}) - $signed({1'b0, cur_g_ff});
            phase_ff <= '0; sweep_ff <= 1'b1;
         end
         if (cmd.set) begin
            lat_f_ff <= cfg.freq; base_f_ff <= cfg.freq; cur_f_ff <= cfg.freq;
            lat_r_ff <= cfg.reson; base_r_ff <= cfg.reson; cur_r_ff <= cfg.reson;
            lat_g_ff <= cfg.gain; base_g_ff <= cfg.gain; cur_g_ff <= cfg.gain;
            sweep_ff <= 1'b0;
         end
         if (cmd.clear) begin
            y1_ff <= '0; y2_ff <= '0;
         end
         if (cmd.advance) begin
            if (ph_sum >= 26'd16777216) begin
               phase_ff <= 25'd16777216; sweep_ff <= 1'b0;
               base_f_ff <= lat_f_ff; cur_f_ff <= lat_f_ff;
               base_r_ff <= lat_r_ff; cur_r_ff <= lat_r_ff;
               base_g_ff <= lat_g_ff; cur_g_ff <= lat_g_ff;
            end else begin
               phase_ff <= ph_sum[24:0];
            end
         end
         if (cmd.interp && sweep_ff) begin
            cur_f_ff <= 15'($signed({1'b0, base_f_ff}) + 17'(pf >>> 24));
            cur_r_ff <= 16'($signed({1'b0, base_r_ff}) + 18'(pr >>> 24));
            cur_g_ff <= 16'($signed({1'b0, base_g_ff}) + 18'(pg >>> 24));
         end
         if (cmd.coefs) begin
            a1_ff <= 18'(prc >>> 15);
            a2_ff <= -$signed({2'b0, rr[31:16]});
         end
         if (cmd.filt) begin
            y2_ff <= y1_ff;
            y1_ff <= ysat;
            if (HW'(ysat) > HW'(24'sh7fffff) && HW > 24) yo_ff <= 24'sh7fffff;
            else if (ysat < -HW'(25'sh800000) && HW > 24) yo_ff <= 24'sh800000;
            else yo_ff <= 24'(ysat);
         end
      end
   end

   assign status.sweeping = sweep_ff;
   assign y_out = yo_ff;
endmodule

@@ rtl/stpr_ctrl.sv @@
// controller sequencing each request through the datapath
module stpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stpr_pkg::func_type   req_func,
   input  stpr_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output stpr_pkg::cmd_type    cmd
);
   import stpr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ADV, S_INTERP, S_LOOK, S_COEF, S_FILT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic rv_ff, rv_in;
   logic cmd_from_sweep_ff, cmd_from_sweep_in;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;

   always_comb begin
      state_in = state_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_func)
                  FUNC_FILTER: state_in = status.sweeping ? S_ADV : S_FILT;
                  FUNC_START: cmd.start = 1'b1;
                  FUNC_SET: begin cmd.set = 1'b1; state_in = S_LOOK; end
                  FUNC_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            cmd.interp = 1'b1;
            state_in = S_LOOK;
         end
         // cosine rom read of the updated frequency
         S_LOOK: begin
            state_in = S_COEF;
         end
         S_COEF: begin
            cmd.coefs = 1'b1;
            state_in = S_IDLE;
         end
         S_FILT: begin
            cmd.filt = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // coefficient update during a sweep continues into the filter
      if (state_ff == S_COEF && cmd_from_sweep_ff) state_in = S_FILT;
   end

   always_comb begin
      cmd_from_sweep_in = cmd_from_sweep_ff;
      if (state_ff == S_IDLE) cmd_from_sweep_in = 1'b0;
      if (state_ff == S_ADV) cmd_from_sweep_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         cmd_from_sweep_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         cmd_from_sweep_ff <= cmd_from_sweep_in;
      end
   end

   assign rsp_valid = rv_ff;
endmodule

@@ rtl/swept_two_pole_resonator_core.sv @@
// top level of the swept two-pole resonator
// A filter request outside a sweep shows its result after the filter
// multiply-accumulate and the output step; during a sweep it goes through the
// controller's steps: phase advance, value interpolation, cosine rom read,
// coefficient update, filter multiply-accumulate, output step. Start and clear
// requests are done in the idle state, set goes through rom read and coefficient update. The
// result waits in an output register; the next request is taken once that
// result has been transferred.
module swept_two_pole_resonator_core (
   input  logic                  clock,
   input  logic                  reset,
   stpr_req_if.sink              req,
   stpr_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [stpr_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [stpr_pkg::CSR_DATA_W-1:0] csr_data
);
   import stpr_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   status_type status;
   logic signed [15:0] smp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq <= '0;
         cfg_ff.reson <= '0;
         cfg_ff.gain <= 16'd32768;
         cfg_ff.rate <= 25'd33554;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_FREQ: cfg_ff.freq <= csr_data[14:0];
            CSR_RESON: cfg_ff.reson <= csr_data[15:0];
            CSR_GAIN: cfg_ff.gain <= csr_data[15:0];
            CSR_RATE: cfg_ff.rate <= csr_data[24:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) smp_ff <= req.sample_in;
   end

   stpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_func  (func_type'(req.func)),
      .status    (status),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd)
   );

   stpr_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .sample (smp_ff),
      .status (status),
      .y_out  (rsp.sample_out)
   );

   assign rsp.sweep_active = status.sweeping;
endmodule
